>>> rtl/core/lci_pkg.sv
// Shared types, constants and widths for the line/circle intersection block.
package lci_pkg;

    localparam int IN_FRAC_BITS  = 8;
    localparam int OUT_FRAC_BITS = 16;

    // Quotient bits produced by each divider before rounding.
    localparam int QUOT_W     = 33;
    localparam int DIV_STAGES = QUOT_W + 3;

    // Discriminant, root and denominator widths.
    localparam int DISC_W     = 62;
    localparam int SQRT_STEPS = 31;
    localparam int ROOT_W     = 31;
    localparam int REM_W      = 33;
    localparam int DEN_W      = 31;
    localparam int NUM_W      = 34;
    localparam int NUMY_W     = 51;

    localparam logic [1:0] CNT_NONE    = 2'd0;
    localparam logic [1:0] CNT_TANGENT = 2'd1;
    localparam logic [1:0] CNT_SECANT  = 2'd2;

    typedef struct packed {
        logic signed [15:0] slope;
        logic signed [15:0] intercept;
        logic        [14:0] radius;
    } t_item;

    typedef struct packed {
        logic        [1:0]  point_count;
        logic signed [31:0] x_first;
        logic signed [31:0] y_first;
        logic signed [31:0] x_second;
        logic signed [31:0] y_second;
    } t_result;

    // Values that ride along with the discriminant through the root stages.
    typedef struct packed {
        logic signed [15:0]      a;
        logic signed [15:0]      b;
        logic signed [31:0]      ab;
        logic        [DEN_W-1:0] den;
        logic        [1:0]       cnt;
    } t_side;

endpackage

>>> rtl/core/lci_div.sv
// Pipelined signed divider: round(num * 2^(SHIFT-1) / den), saturated to 32 bits.
module lci_div #(
    parameter int NUM_W = lci_pkg::NUM_W,
    parameter int DEN_W = lci_pkg::DEN_W,
    parameter int SHIFT = lci_pkg::OUT_FRAC_BITS + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic                    o_valid,
    output logic signed [31:0]      o_quot
);

    localparam int QW = lci_pkg::QUOT_W;
    localparam int NW = NUM_W + SHIFT;
    localparam int TW = NW - QW;
    localparam logic [QW-1:0] LIM_POS = QW'(32'h7FFF_FFFF);
    localparam logic [QW-1:0] LIM_NEG = QW'(32'h8000_0000);

    // front stage: sign and magnitude
    logic             r_a_v;
    logic             r_a_neg;
    logic [NUM_W-1:0] r_a_mag;
    logic [DEN_W-1:0] r_a_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
        end
        r_a_neg <= i_num[NUM_W-1];
        r_a_mag <= i_num[NUM_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
        r_a_den <= i_den;
    end

    // long division stages, index 0 holds the overflow check result
    logic             r_v   [0:QW];
    logic             r_neg [0:QW];
    logic             r_sat [0:QW];
    logic [DEN_W-1:0] r_den [0:QW];
    logic [DEN_W-1:0] r_rem [0:QW];
    logic [QW-1:0]    r_low [0:QW];
    logic [QW-1:0]    r_q   [0:QW];

    logic [NW-1:0]       w_n;
    logic [TW-1:0]       w_t;
    logic [TW+DEN_W-1:0] w_t_ext;

    assign w_n     = {r_a_mag, {SHIFT{1'b0}}};
    assign w_t     = w_n[NW-1:QW];
    assign w_t_ext = {{DEN_W{1'b0}}, w_t};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_a_v;
        end
        r_neg[0] <= r_a_neg;
        r_sat[0] <= w_t_ext >= {{TW{1'b0}}, r_a_den};
        r_den[0] <= r_a_den;
        r_rem[0] <= w_t_ext[DEN_W-1:0];
        r_low[0] <= w_n[QW-1:0];
        r_q[0]   <= '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DEN_W:0] w_rem2;
        logic           w_ge;
        logic [DEN_W:0] w_diff;

        assign w_rem2 = {r_rem[k], r_low[k][QW-1]};
        assign w_ge   = w_rem2 >= {1'b0, r_den[k]};
        assign w_diff = w_rem2 - {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_neg[k+1] <= r_neg[k];
            r_sat[k+1] <= r_sat[k];
            r_den[k+1] <= r_den[k];
            r_rem[k+1] <= w_ge ? w_diff[DEN_W-1:0] : w_rem2[DEN_W-1:0];
            r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
            r_q[k+1]   <= {r_q[k][QW-2:0], w_ge};
        end
    end

    // round half away from zero, clamp, restore sign
    logic [QW:0]   w_qp1;
    logic [QW-1:0] w_rnd;
    logic [QW-1:0] w_lim;
    logic [QW-1:0] w_mag;

    assign w_qp1 = {1'b0, r_q[QW]} + {{QW{1'b0}}, 1'b1};
    assign w_rnd = w_qp1[QW:1];
    assign w_lim = r_neg[QW] ? LIM_NEG : LIM_POS;
    assign w_mag = (r_sat[QW] || w_rnd > w_lim) ? w_lim : w_rnd;

    logic               r_o_v;
    logic signed [31:0] r_o_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_v[QW];
        end
        r_o_quot <= r_neg[QW] ? -$signed(w_mag[31:0]) : $signed(w_mag[31:0]);
    end

    assign o_valid = r_o_v;
    assign o_quot  = r_o_quot;

endmodule

>>> rtl/core/line_circle_intersection_top.sv
// Top level of the pipelined line/circle intersection block.
//
// Usage: raise start with an item (slope a, intercept b, radius r, Q-format
// inputs) on i_item; the item is taken at any clock edge with start high and
// busy low. busy never rises, so one item can enter in every cycle.
// Each item yields exactly one result on o_result, shown for one cycle with
// o_strobe high: point_count (0 none, 1 tangent, 2 secant) and the two points
// in signed Q16.16 by default, saturated; both points equal on a tangent and
// all coordinates zero when there is no point.
// Throughput is one item per cycle. The pipeline is made of the 31 one-bit
// root stages and the 36-stage dividers (one quotient bit per long-division
// step), plus ten stages of capture, products, discriminant, rounding,
// numerators and output.
// Results leave in acceptance order. The receiver cannot hold results off,
// so the pipeline never stalls.
// Reset (synchronous, active low) clears every valid bit; items in flight
// are dropped and no strobe follows until new items arrive.
module line_circle_intersection_top #(
    parameter int IN_FRAC_BITS  = lci_pkg::IN_FRAC_BITS,
    parameter int OUT_FRAC_BITS = lci_pkg::OUT_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  lci_pkg::t_item   i_item,
    output logic             o_strobe,
    output lci_pkg::t_result o_result
);

    localparam int DW   = lci_pkg::DEN_W;
    localparam int DYW  = lci_pkg::DEN_W + IN_FRAC_BITS;
    localparam int STP  = lci_pkg::SQRT_STEPS;
    localparam int DLAT = lci_pkg::DIV_STAGES;
    localparam logic [DW-1:0] S_SQ = DW'(1) << (2 * IN_FRAC_BITS);

    // The pipeline always advances.
    assign busy = 1'b0;

    // ---- stage 1: capture the item
    logic               r1_v;
    logic signed [15:0] r1_a;
    logic signed [15:0] r1_b;
    logic        [14:0] r1_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
        r1_a <= i_item.slope;
        r1_b <= i_item.intercept;
        r1_r <= i_item.radius;
    end

    // ---- stage 2: squares and cross product
    logic               r2_v;
    logic        [30:0] r2_aa;
    logic        [30:0] r2_bb;
    logic        [29:0] r2_rr;
    logic signed [31:0] r2_ab;
    logic signed [15:0] r2_a;
    logic signed [15:0] r2_b;
    logic signed [31:0] w2_aa;
    logic signed [31:0] w2_bb;

    assign w2_aa = r1_a * r1_a;
    assign w2_bb = r1_b * r1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_aa <= w2_aa[30:0];
        r2_bb <= w2_bb[30:0];
        r2_rr <= r1_r * r1_r;
        r2_ab <= r1_a * r1_b;
        r2_a  <= r1_a;
        r2_b  <= r1_b;
    end

    // ---- stage 3: denominator S^2 + a^2, scaled b^2
    logic               r3_v;
    logic [DW-1:0]      r3_den;
    logic [61:0]        r3_bs;
    logic [29:0]        r3_rr;
    logic signed [31:0] r3_ab;
    logic signed [15:0] r3_a;
    logic signed [15:0] r3_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_den <= S_SQ + r2_aa;
        r3_bs  <= 62'(r2_bb) << (2 * IN_FRAC_BITS);
        r3_rr  <= r2_rr;
        r3_ab  <= r2_ab;
        r3_a   <= r2_a;
        r3_b   <= r2_b;
    end

    // ---- stage 4: r^2 * den
    logic               r4_v;
    logic [61:0]        r4_rd;
    logic [61:0]        r4_bs;
    logic [DW-1:0]      r4_den;
    logic signed [31:0] r4_ab;
    logic signed [15:0] r4_a;
    logic signed [15:0] r4_b;
    logic [60:0]        w4_rd;

    assign w4_rd = r3_rr * r3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_rd  <= {1'b0, w4_rd};
        r4_bs  <= r3_bs;
        r4_den <= r3_den;
        r4_ab  <= r3_ab;
        r4_a   <= r3_a;
        r4_b   <= r3_b;
    end

    // ---- stage 5: discriminant sign and value; feeds root stage 0
    logic           r_sq_v    [0:STP];
    logic [61:0]    r_sq_dsh  [0:STP];
    logic [30:0]    r_sq_root [0:STP];
    logic [32:0]    r_sq_rem  [0:STP];
    lci_pkg::t_side r_sq_side [0:STP];

    logic [1:0]  w5_cnt;
    logic [61:0] w5_disc;

    assign w5_disc = r4_rd - r4_bs;

    always_comb begin
        priority if (r4_rd < r4_bs) begin
            w5_cnt = lci_pkg::CNT_NONE;
        end else if (r4_rd == r4_bs) begin
            w5_cnt = lci_pkg::CNT_TANGENT;
        end else begin
            w5_cnt = lci_pkg::CNT_SECANT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r4_v;
        end
        // drop the value of a negative discriminant; the root of zero is zero
        r_sq_dsh[0]  <= (w5_cnt == lci_pkg::CNT_NONE) ? '0 : w5_disc;
        r_sq_root[0] <= '0;
        r_sq_rem[0]  <= '0;
        r_sq_side[0] <= '{a: r4_a, b: r4_b, ab: r4_ab, den: r4_den, cnt: w5_cnt};
    end

    // ---- root stages: one result bit per stage
    for (genvar k = 0; k < STP; k++) begin : g_root
        logic [34:0] w_rem2;
        logic [34:0] w_trial;
        logic        w_ge;
        logic [34:0] w_diff;

        assign w_rem2  = {r_sq_rem[k], r_sq_dsh[k][61:60]};
        assign w_trial = {2'b00, r_sq_root[k], 2'b01};
        assign w_ge    = w_rem2 >= w_trial;
        assign w_diff  = w_rem2 - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            r_sq_dsh[k+1]  <= {r_sq_dsh[k][59:0], 2'b00};
            r_sq_root[k+1] <= {r_sq_root[k][29:0], w_ge};
            r_sq_rem[k+1]  <= w_ge ? w_diff[32:0] : w_rem2[32:0];
            r_sq_side[k+1] <= r_sq_side[k];
        end
    end

    // ---- round the root to nearest: bump when the remainder exceeds it
    logic           r6_v;
    logic [31:0]    r6_sq;
    lci_pkg::t_side r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r_sq_v[STP];
        end
        r6_sq   <= {1'b0, r_sq_root[STP]}
                 + {31'd0, ({2'b00, r_sq_root[STP]} < r_sq_rem[STP])};
        r6_side <= r_sq_side[STP];
    end

    // ---- numerators -ab -/+ sq
    logic                            r7_v;
    logic signed [lci_pkg::NUM_W-1:0] r7_num1;
    logic signed [lci_pkg::NUM_W-1:0] r7_num2;
    lci_pkg::t_side                  r7_side;
    logic signed [lci_pkg::NUM_W-1:0] w7_nab;
    logic signed [lci_pkg::NUM_W-1:0] w7_sq;

    assign w7_nab = -(lci_pkg::NUM_W'(r6_side.ab));
    assign w7_sq  = $signed({2'b00, r6_sq});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        r7_num1 <= w7_nab - w7_sq;
        r7_num2 <= w7_nab + w7_sq;
        r7_side <= r6_side;
    end

    // ---- products for the y numerators
    logic                             r8_v;
    logic signed [49:0]               r8_p1;
    logic signed [49:0]               r8_p2;
    logic signed [47:0]               r8_pb;
    logic signed [lci_pkg::NUM_W-1:0] r8_num1;
    logic signed [lci_pkg::NUM_W-1:0] r8_num2;
    logic [DW-1:0]                    r8_den;
    logic [1:0]                       r8_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else begin
            r8_v <= r7_v;
        end
        r8_p1   <= r7_num1 * r7_side.a;
        r8_p2   <= r7_num2 * r7_side.a;
        r8_pb   <= r7_side.b * $signed({1'b0, r7_side.den});
        r8_num1 <= r7_num1;
        r8_num2 <= r7_num2;
        r8_den  <= r7_side.den;
        r8_cnt  <= r7_side.cnt;
    end

    // ---- y numerators a*num + b*den
    logic                              r9_v;
    logic signed [lci_pkg::NUMY_W-1:0] r9_ny1;
    logic signed [lci_pkg::NUMY_W-1:0] r9_ny2;
    logic signed [lci_pkg::NUM_W-1:0]  r9_num1;
    logic signed [lci_pkg::NUM_W-1:0]  r9_num2;
    logic [DW-1:0]                     r9_den;
    logic [1:0]                        r9_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else begin
            r9_v <= r8_v;
        end
        r9_ny1  <= lci_pkg::NUMY_W'(r8_p1) + lci_pkg::NUMY_W'(r8_pb);
        r9_ny2  <= lci_pkg::NUMY_W'(r8_p2) + lci_pkg::NUMY_W'(r8_pb);
        r9_num1 <= r8_num1;
        r9_num2 <= r8_num2;
        r9_den  <= r8_den;
        r9_cnt  <= r8_cnt;
    end

    // ---- four dividers in lockstep
    logic               w_vx1;
    logic               w_vy1;
    logic               w_vx2;
    logic               w_vy2;
    logic signed [31:0] w_x1;
    logic signed [31:0] w_y1;
    logic signed [31:0] w_x2;
    logic signed [31:0] w_y2;
    logic [DYW-1:0]     w_den_y;

    assign w_den_y = {r9_den, {IN_FRAC_BITS{1'b0}}};

    lci_div #(.NUM_W(lci_pkg::NUM_W), .DEN_W(DW), .SHIFT(OUT_FRAC_BITS + 1)) u_div_x1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r9_v), .i_num(r9_num1),
        .i_den(r9_den), .o_valid(w_vx1), .o_quot(w_x1)
    );

    lci_div #(.NUM_W(lci_pkg::NUMY_W), .DEN_W(DYW), .SHIFT(OUT_FRAC_BITS + 1)) u_div_y1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r9_v), .i_num(r9_ny1),
        .i_den(w_den_y), .o_valid(w_vy1), .o_quot(w_y1)
    );

    lci_div #(.NUM_W(lci_pkg::NUM_W), .DEN_W(DW), .SHIFT(OUT_FRAC_BITS + 1)) u_div_x2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r9_v), .i_num(r9_num2),
        .i_den(r9_den), .o_valid(w_vx2), .o_quot(w_x2)
    );

    lci_div #(.NUM_W(lci_pkg::NUMY_W), .DEN_W(DYW), .SHIFT(OUT_FRAC_BITS + 1)) u_div_y2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r9_v), .i_num(r9_ny2),
        .i_den(w_den_y), .o_valid(w_vy2), .o_quot(w_y2)
    );

    // hold the point count alongside the dividers
    logic [1:0] r_cnt_dly [0:DLAT-1];

    always_ff @(posedge i_clk) begin
        r_cnt_dly[0] <= r9_cnt;
    end

    for (genvar k = 1; k < DLAT; k++) begin : g_cnt
        always_ff @(posedge i_clk) begin
            r_cnt_dly[k] <= r_cnt_dly[k-1];
        end
    end

    // ---- output register: zero the coordinates when there is no point
    logic             r_strobe;
    lci_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_vx1;
        end
        r_result.point_count <= r_cnt_dly[DLAT-1];
        if (r_cnt_dly[DLAT-1] == lci_pkg::CNT_NONE) begin
            r_result.x_first  <= '0;
            r_result.y_first  <= '0;
            r_result.x_second <= '0;
            r_result.y_second <= '0;
        end else begin
            r_result.x_first  <= w_x1;
            r_result.y_first  <= w_y1;
            r_result.x_second <= w_x2;
            r_result.y_second <= w_y2;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // ---- checks
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vx1 == w_vy1) && (w_vx1 == w_vx2) && (w_vx1 == w_vy2))
        else $error("dividers out of step");

    a_count_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.point_count == lci_pkg::CNT_NONE)
                  || (o_result.point_count == lci_pkg::CNT_TANGENT)
                  || (o_result.point_count == lci_pkg::CNT_SECANT))
        else $error("bad point count");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.point_count == lci_pkg::CNT_NONE) |->
        (o_result.x_first == 32'sd0) && (o_result.y_first == 32'sd0)
        && (o_result.x_second == 32'sd0) && (o_result.y_second == 32'sd0))
        else $error("coordinates not zero without a point");

    a_tangent_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.point_count == lci_pkg::CNT_TANGENT) |->
        (o_result.x_first == o_result.x_second)
        && (o_result.y_first == o_result.y_second))
        else $error("tangent points differ");

endmodule
